// ===== hdl/bisection_cubic_root_finder_macros.svh =====
// Assertion macros shared by the bisection root finder RTL.
`ifndef BISECTION_CUBIC_ROOT_FINDER_MACROS_SVH
`define BISECTION_CUBIC_ROOT_FINDER_MACROS_SVH
`ifndef SYNTHESIS
`define BCRF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcrf: assertion failed");
`define BCRF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcrf: assertion failed");
`else
`define BCRF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BCRF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/bcrf_pkg.sv =====
// Types, constants and microcode program of the bisection cubic root finder.
package bcrf_pkg;

    localparam int DEF_WORD_BITS = 32;
    localparam int DEF_FRAC_BITS = 16;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_W       = 16;
    localparam int PC_BITS     = 6;

    // Saturation bound of products and polynomial values.
    localparam logic [63:0] P_MAX = 64'h3FFF_FFFF_FFFF_FFFF;

    localparam logic [5:0] ITER_MAX = 6'd63;

    localparam logic [CFG_W-1:0] RST_SCAN_STEP  = 16'd6554;
    localparam logic [CFG_W-1:0] RST_SCAN_LIMIT = 16'd1000;
    localparam logic [CFG_W-1:0] RST_TOLERANCE  = 16'd1;

    localparam logic [1:0] CFG_SCAN_STEP  = 2'd0;
    localparam logic [1:0] CFG_SCAN_LIMIT = 2'd1;
    localparam logic [1:0] CFG_TOLERANCE  = 2'd2;

    localparam logic [1:0] ST_SMALL   = 2'd0;
    localparam logic [1:0] ST_NARROW  = 2'd1;
    localparam logic [1:0] ST_NO_SIGN = 2'd2;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_SEL_LO,
        OP_SEL_HI,
        OP_SEL_MID,
        OP_SQ,
        OP_X2,
        OP_MLO,
        OP_MHI,
        OP_ACCHI,
        OP_CUBE,
        OP_POLY,
        OP_SAVE_LO,
        OP_SAVE_HI,
        OP_SAVE_MID,
        OP_SHIFT,
        OP_INIT_BIS,
        OP_WIDTH,
        OP_UPDATE,
        OP_END_FAIL,
        OP_END_WIDTH,
        OP_END_SMALL
    } t_op;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_SCAN_EXIT,
        COND_LIMIT,
        COND_WSTOP,
        COND_SMALL
    } t_cond;

    typedef struct packed {
        t_op                op;
        t_cond              cond;
        logic [PC_BITS-1:0] target;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic en;
    } t_ctl;

    typedef struct packed {
        logic scan_exit;
        logic at_limit;
        logic wstop;
        logic small_p;
    } t_flags;

    localparam logic [PC_BITS-1:0] L_SCAN     = 6'd0;
    localparam logic [PC_BITS-1:0] L_BIS_INIT = 6'd20;
    localparam logic [PC_BITS-1:0] L_BIS_TEST = 6'd21;
    localparam logic [PC_BITS-1:0] L_FAIL     = 6'd34;
    localparam logic [PC_BITS-1:0] L_NARROW   = 6'd35;
    localparam logic [PC_BITS-1:0] L_SMALL    = 6'd36;

    // Microcode program. Each cubic takes seven steps on the one multiplier.
    function automatic t_uword ucode_rom(input logic [PC_BITS-1:0] pc);
        t_uword w;
        w = '{OP_NOP, COND_ALWAYS, L_SCAN};
        unique case (pc)
            6'd0:  w = '{OP_SEL_LO,   COND_NEXT,      L_SCAN};
            6'd1:  w = '{OP_SQ,       COND_NEXT,      L_SCAN};
            6'd2:  w = '{OP_X2,       COND_NEXT,      L_SCAN};
            6'd3:  w = '{OP_MLO,      COND_NEXT,      L_SCAN};
            6'd4:  w = '{OP_MHI,      COND_NEXT,      L_SCAN};
            6'd5:  w = '{OP_ACCHI,    COND_NEXT,      L_SCAN};
            6'd6:  w = '{OP_CUBE,     COND_NEXT,      L_SCAN};
            6'd7:  w = '{OP_POLY,     COND_NEXT,      L_SCAN};
            6'd8:  w = '{OP_SAVE_LO,  COND_NEXT,      L_SCAN};
            6'd9:  w = '{OP_SEL_HI,   COND_NEXT,      L_SCAN};
            6'd10: w = '{OP_SQ,       COND_NEXT,      L_SCAN};
            6'd11: w = '{OP_X2,       COND_NEXT,      L_SCAN};
            6'd12: w = '{OP_MLO,      COND_NEXT,      L_SCAN};
            6'd13: w = '{OP_MHI,      COND_NEXT,      L_SCAN};
            6'd14: w = '{OP_ACCHI,    COND_NEXT,      L_SCAN};
            6'd15: w = '{OP_CUBE,     COND_NEXT,      L_SCAN};
            6'd16: w = '{OP_POLY,     COND_NEXT,      L_SCAN};
            6'd17: w = '{OP_SAVE_HI,  COND_NEXT,      L_SCAN};
            6'd18: w = '{OP_NOP,      COND_SCAN_EXIT, L_BIS_INIT};
            6'd19: w = '{OP_SHIFT,    COND_ALWAYS,    L_SCAN};
            6'd20: w = '{OP_INIT_BIS, COND_LIMIT,     L_FAIL};
            6'd21: w = '{OP_NOP,      COND_WSTOP,     L_NARROW};
            6'd22: w = '{OP_SEL_MID,  COND_NEXT,      L_SCAN};
            6'd23: w = '{OP_SQ,       COND_NEXT,      L_SCAN};
            6'd24: w = '{OP_X2,       COND_NEXT,      L_SCAN};
            6'd25: w = '{OP_MLO,      COND_NEXT,      L_SCAN};
            6'd26: w = '{OP_MHI,      COND_NEXT,      L_SCAN};
            6'd27: w = '{OP_ACCHI,    COND_NEXT,      L_SCAN};
            6'd28: w = '{OP_CUBE,     COND_NEXT,      L_SCAN};
            6'd29: w = '{OP_POLY,     COND_NEXT,      L_SCAN};
            6'd30: w = '{OP_SAVE_MID, COND_NEXT,      L_SCAN};
            6'd31: w = '{OP_NOP,      COND_SMALL,     L_SMALL};
            6'd32: w = '{OP_UPDATE,   COND_NEXT,      L_SCAN};
            6'd33: w = '{OP_WIDTH,    COND_ALWAYS,    L_BIS_TEST};
            6'd34: w = '{OP_END_FAIL,  COND_NEXT,     L_SCAN};
            6'd35: w = '{OP_END_WIDTH, COND_NEXT,     L_SCAN};
            6'd36: w = '{OP_END_SMALL, COND_NEXT,     L_SCAN};
            default: w = '{OP_NOP, COND_ALWAYS, L_SCAN};
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/bcrf_useq.sv =====
// Microcode sequencer: step counter, program table and conditional jumps.
`include "bisection_cubic_root_finder_macros.svh"
module bcrf_useq import bcrf_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  t_flags i_flags,
    input  logic   i_out_free,
    output t_ctl   o_ctl,
    output logic   o_busy,
    output logic   o_done
);

    logic [PC_BITS-1:0] r_pc, n_pc;
    logic               r_busy, n_busy;
    t_uword             w_word;
    logic               w_is_end;
    logic               w_hold;
    logic               w_jump;

    assign w_word   = ucode_rom(r_pc);
    assign w_is_end = (w_word.op == OP_END_FAIL) || (w_word.op == OP_END_WIDTH) ||
                      (w_word.op == OP_END_SMALL);
    // A finishing step waits until the result register can take the word.
    assign w_hold   = w_is_end && !i_out_free;

    always_comb begin
        unique case (w_word.cond)
            COND_NEXT:      w_jump = 1'b0;
            COND_ALWAYS:    w_jump = 1'b1;
            COND_SCAN_EXIT: w_jump = i_flags.scan_exit;
            COND_LIMIT:     w_jump = i_flags.at_limit;
            COND_WSTOP:     w_jump = i_flags.wstop;
            COND_SMALL:     w_jump = i_flags.small_p;
            default:        w_jump = 1'b0;
        endcase
    end

    always_comb begin
        n_pc   = r_pc;
        n_busy = r_busy;
        if (i_start) begin
            n_pc   = L_SCAN;
            n_busy = 1'b1;
        end else if (r_busy && !w_hold) begin
            if (w_is_end) begin
                n_pc   = L_SCAN;
                n_busy = 1'b0;
            end else if (w_jump) begin
                n_pc = w_word.target;
            end else begin
                n_pc = r_pc + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= L_SCAN;
            r_busy <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_busy <= n_busy;
        end
    end

    assign o_ctl.op = w_word.op;
    assign o_ctl.en = r_busy && !w_hold;
    assign o_busy   = r_busy;
    assign o_done   = r_busy && w_is_end && i_out_free;

    `BCRF_ASSERT_IMP(a_idle_at_entry, i_clk, i_rst_n, !r_busy, r_pc == L_SCAN)
    `BCRF_ASSERT_NXT(a_done_goes_idle, i_clk, i_rst_n, o_done && !i_start, !r_busy)
    `BCRF_ASSERT_NXT(a_hold_keeps_pc, i_clk, i_rst_n, r_busy && w_hold && !i_start,
                     r_pc == $past(r_pc))

endmodule

// ===== hdl/bcrf_datapath.sv =====
// Datapath: interval registers, one shared multiplier and cubic evaluation.
module bcrf_datapath import bcrf_pkg::*; #(
    parameter int WORD_BITS = DEF_WORD_BITS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_load,
    input  logic signed [31:0]       i_start_low,
    input  logic signed [31:0]       i_start_high,
    input  t_ctl                     i_ctl,
    input  logic [CFG_W-1:0]         i_scan_step,
    input  logic [CFG_W-1:0]         i_scan_limit,
    input  logic [CFG_W-1:0]         i_tolerance,
    output t_flags                   o_flags,
    output logic signed [31:0]       o_root,
    output logic [5:0]               o_iterations
);

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int PRW = 2 * W;
    localparam int ACW = 3 * W;
    localparam int IW  = (W > 32) ? W : 32;
    localparam int CW  = (ACW > 64) ? ACW : 64;
    localparam int PEW = 66;
    localparam int SW  = W + 2;

    localparam logic [CW-1:0] PMAX_C = CW'(P_MAX);

    typedef struct packed {
        logic neg;
        logic nz;
    } t_sgn;

    function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] v);
        return v[W-1] ? W'(-v) : W'(v);
    endfunction

    function automatic logic opposite(input t_sgn a, input t_sgn b);
        return a.nz && b.nz && (a.neg != b.neg);
    endfunction

    function automatic logic signed [W-1:0] add_step(input logic signed [W-1:0] v,
                                                      input logic [CFG_W-1:0] s);
        logic signed [SW-1:0] sum;
        logic signed [SW-1:0] wmax;
        wmax = signed'(SW'({(W-1){1'b1}}));
        sum  = SW'(v) + signed'(SW'(s));
        return (sum > wmax) ? wmax[W-1:0] : sum[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] from32(input logic signed [31:0] v);
        logic signed [IW-1:0] e;
        logic signed [IW-1:0] wmax;
        logic signed [IW-1:0] wmin;
        e    = IW'(v);
        wmax = signed'(IW'({(W-1){1'b1}}));
        wmin = ~wmax;
        if (e > wmax) begin
            e = wmax;
        end else if (e < wmin) begin
            e = wmin;
        end
        return e[W-1:0];
    endfunction

    logic signed [W-1:0]   r_lo, r_hi, r_mid, r_x;
    logic [W-1:0]          r_xmag;
    logic [PRW-1:0]        r_prod, r_x2;
    logic [ACW-1:0]        r_acc;
    logic signed [63:0]    r_x3, r_p;
    t_sgn                  r_slo, r_shi, r_smid;
    logic                  r_small, r_wstop;
    logic [CFG_W-1:0]      r_step;
    logic [5:0]            r_iter;

    logic [W-1:0]          w_mul_a;
    logic [PRW-1:0]        w_prod;
    logic [CW-1:0]         w_sh2, w_sh3, w_sat3;
    logic [PRW-1:0]        w_x2;
    logic [62:0]           w_mag3;
    logic signed [63:0]    w_x3;
    logic signed [PEW-1:0] w_pv, w_x3e, w_xe, w_c9, w_pmax;
    logic signed [63:0]    w_p;
    t_sgn                  w_psgn;
    logic signed [63:0]    w_tol;
    logic                  w_small;
    logic signed [W:0]     w_sum, w_diff;
    logic [W:0]            w_absd;
    logic                  w_wstop;
    logic signed [W-1:0]   w_mid;

    // Shared multiplier: the squaring and the two halves of the cube product.
    always_comb begin
        unique case (i_ctl.op)
            OP_SQ:   w_mul_a = r_xmag;
            OP_MLO:  w_mul_a = r_x2[W-1:0];
            default: w_mul_a = r_x2[PRW-1:W];
        endcase
    end
    assign w_prod = PRW'(w_mul_a) * PRW'(r_xmag);

    assign w_sh2 = CW'(r_prod) >> F;
    assign w_x2  = (w_sh2 > PMAX_C) ? PMAX_C[PRW-1:0] : w_sh2[PRW-1:0];

    assign w_sh3  = CW'(r_acc) >> F;
    assign w_sat3 = (w_sh3 > PMAX_C) ? PMAX_C : w_sh3;
    assign w_mag3 = w_sat3[62:0];
    assign w_x3   = r_x[W-1] ? -signed'({1'b0, w_mag3}) : signed'({1'b0, w_mag3});

    assign w_x3e  = PEW'(r_x3);
    assign w_xe   = PEW'(r_x);
    assign w_c9   = signed'(PEW'(9)) <<< F;
    assign w_pmax = signed'(PEW'(P_MAX));
    assign w_pv   = w_x3e - (w_xe <<< 2) - w_c9;

    always_comb begin
        if (w_pv > w_pmax) begin
            w_p = w_pmax[63:0];
        end else if (w_pv < -w_pmax) begin
            w_p = -(w_pmax[63:0]);
        end else begin
            w_p = w_pv[63:0];
        end
    end

    assign w_psgn.neg = r_p[63];
    assign w_psgn.nz  = |r_p;
    assign w_tol      = signed'(64'(i_tolerance));
    assign w_small    = (r_p < w_tol) && (r_p > -w_tol);

    assign w_sum  = (W+1)'(r_lo) + (W+1)'(r_hi);
    assign w_mid  = w_sum[W:1];
    assign w_diff = (W+1)'(r_lo) - (W+1)'(r_hi);
    assign w_absd = w_diff[W] ? (W+1)'(-w_diff) : (W+1)'(w_diff);
    assign w_wstop = (w_absd < (W+1)'(i_tolerance)) || (w_absd <= (W+1)'(1));

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_lo   <= from32(i_start_low);
            r_hi   <= from32(i_start_high);
            r_step <= '0;
            r_iter <= '0;
        end else if (i_ctl.en) begin
            unique case (i_ctl.op)
                OP_SEL_LO: begin
                    r_x    <= r_lo;
                    r_xmag <= mag_w(r_lo);
                end
                OP_SEL_HI: begin
                    r_x    <= r_hi;
                    r_xmag <= mag_w(r_hi);
                end
                OP_SEL_MID: begin
                    r_mid  <= w_mid;
                    r_x    <= w_mid;
                    r_xmag <= mag_w(w_mid);
                    r_iter <= (r_iter == ITER_MAX) ? r_iter : r_iter + 6'd1;
                end
                OP_SQ, OP_MLO: begin
                    r_prod <= w_prod;
                end
                OP_X2: begin
                    r_x2 <= w_x2;
                end
                OP_MHI: begin
                    r_acc  <= ACW'(r_prod);
                    r_prod <= w_prod;
                end
                OP_ACCHI: begin
                    r_acc <= r_acc + {r_prod, {W{1'b0}}};
                end
                OP_CUBE: begin
                    r_x3 <= w_x3;
                end
                OP_POLY: begin
                    r_p <= w_p;
                end
                OP_SAVE_LO: begin
                    r_slo <= w_psgn;
                end
                OP_SAVE_HI: begin
                    r_shi <= w_psgn;
                end
                OP_SAVE_MID: begin
                    r_smid  <= w_psgn;
                    r_small <= w_small;
                end
                OP_SHIFT: begin
                    r_lo   <= add_step(r_lo, i_scan_step);
                    r_hi   <= add_step(r_hi, i_scan_step);
                    r_step <= r_step + 16'd1;
                end
                OP_INIT_BIS: begin
                    r_mid   <= r_lo;
                    r_wstop <= w_wstop;
                end
                OP_WIDTH: begin
                    r_wstop <= w_wstop;
                end
                OP_UPDATE: begin
                    // The sign at the low end only changes when the low end moves.
                    if (opposite(r_smid, r_slo)) begin
                        r_hi <= r_mid;
                    end else begin
                        r_lo  <= r_mid;
                        r_slo <= r_smid;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    logic signed [IW-1:0] w_root_e;
    assign w_root_e = IW'(r_mid);

    assign o_flags.at_limit  = (r_step == i_scan_limit);
    assign o_flags.scan_exit = opposite(r_slo, r_shi) || (r_step == i_scan_limit);
    assign o_flags.wstop     = r_wstop;
    assign o_flags.small_p   = r_small;
    assign o_root            = w_root_e[31:0];
    assign o_iterations      = r_iter;

endmodule

// ===== hdl/bisection_cubic_root_finder.sv =====
// A scan step costs two cubic evaluations of seven steps each on the one shared
// multiplier; a bisection costs one evaluation plus six control steps.
// One word is worked on at a time; the next is taken as soon as the result is registered.
// Reset (synchronous, active low) idles the sequencer, empties the output register
// and loads the configuration defaults; there is no clearing pass.
`include "bisection_cubic_root_finder_macros.svh"
module bisection_cubic_root_finder import bcrf_pkg::*; #(
    parameter int WORD_BITS = DEF_WORD_BITS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_addr,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [31:0] start_low, [63:32] start_high
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [31:0] root, [37:32] iterations, [39:38] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]             m_axis_tuser
);

    logic [CFG_W-1:0] r_scan_step, r_scan_limit, r_tolerance;
    logic             r_out_valid;
    logic [31:0]      r_root;
    logic [5:0]       r_iter;
    logic [1:0]       r_status;

    logic             w_accept;
    logic             w_out_free;
    logic             w_busy;
    logic             w_done;
    t_ctl             w_ctl;
    t_flags           w_flags;
    logic [31:0]      w_root;
    logic [5:0]       w_iter;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_step  <= RST_SCAN_STEP;
            r_scan_limit <= RST_SCAN_LIMIT;
            r_tolerance  <= RST_TOLERANCE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SCAN_STEP:  r_scan_step  <= i_cfg_wdata;
                CFG_SCAN_LIMIT: r_scan_limit <= i_cfg_wdata;
                CFG_TOLERANCE:  r_tolerance  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    bcrf_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_flags    (w_flags),
        .i_out_free (w_out_free),
        .o_ctl      (w_ctl),
        .o_busy     (w_busy),
        .o_done     (w_done)
    );

    bcrf_datapath #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_load       (w_accept),
        .i_start_low  (signed'(s_axis_tdata[31:0])),
        .i_start_high (signed'(s_axis_tdata[63:32])),
        .i_ctl        (w_ctl),
        .i_scan_step  (r_scan_step),
        .i_scan_limit (r_scan_limit),
        .i_tolerance  (r_tolerance),
        .o_flags      (w_flags),
        .o_root       (w_root),
        .o_iterations (w_iter)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            unique case (w_ctl.op)
                OP_END_FAIL: begin
                    r_root   <= '0;
                    r_iter   <= '0;
                    r_status <= ST_NO_SIGN;
                end
                OP_END_SMALL: begin
                    r_root   <= w_root;
                    r_iter   <= w_iter;
                    r_status <= ST_SMALL;
                end
                default: begin
                    r_root   <= w_root;
                    r_iter   <= w_iter;
                    r_status <= ST_NARROW;
                end
            endcase
        end
    end

    assign s_axis_tready = !w_busy;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_iter, r_root};
    assign m_axis_tuser  = r_status;

    `BCRF_ASSERT_IMP(a_done_has_slot, i_clk, i_rst_n, w_done, !r_out_valid || m_axis_tready)
    `BCRF_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, w_accept, w_busy)
    `BCRF_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, w_busy, !w_accept)

endmodule
